// ----- sv/fsw_pkg.sv -----
// Package for the flash slot wear leveller: item types, codes, constants and the
// header checksum function. Depends on nothing; imported by all but fsw_stream_if.
package fsw_pkg;

    // Number of slots in the rotation and the derived comparison constants.
    localparam int SLOT_COUNT = 4;
    localparam logic [7:0] SLOT_LIMIT = 8'(SLOT_COUNT);
    localparam logic [7:0] LAST_SLOT = 8'(SLOT_COUNT - 1);
    localparam logic [8:0] SLOT_WRAP = 9'(SLOT_COUNT);

    // Half the sequence space, used by the serial-number compare.
    localparam logic [31:0] SERIAL_HALF = 32'hFFFF_FFFF / 32'd2;

    // Operation codes.
    localparam logic [1:0] OP_SCAN    = 2'd0;
    localparam logic [1:0] OP_PREPARE = 2'd1;
    localparam logic [1:0] OP_COMMIT  = 2'd2;
    localparam logic [1:0] OP_ERASE   = 2'd3;

    // Configuration register indexes and reset values.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MARKER  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAY = 2'd2;
    localparam int CFG_DATA_W = 32;
    localparam logic [31:0] MARKER_RESET  = 32'd0;
    localparam logic [15:0] VERSION_RESET = 16'd1;
    localparam logic [15:0] MAX_PAY_RESET = 16'd2032;

    typedef struct packed {
        logic [1:0]  operation;
        logic [1:0]  slot_index;
        logic [31:0] stored_sequence;
        logic [31:0] stored_marker;
        logic [15:0] payload_size;
        logic [15:0] stored_version;
        logic [31:0] stored_checksum;
    } in_item_t;

    typedef struct packed {
        logic        slot_valid;
        logic [1:0]  record_slot;
        logic [31:0] newest_sequence;
        logic [1:0]  next_slot;
        logic        config_found;
        logic        scan_done;
        logic [31:0] new_sequence;
        logic [31:0] new_checksum;
    } out_item_t;

    typedef struct packed {
        logic [31:0] marker;
        logic [15:0] version;
        logic [15:0] max_payload;
    } cfg_t;

    typedef struct packed {
        logic        hdr_ok;
        logic [31:0] checksum;
        logic [31:0] prep_seq;
    } chk_t;

    // Negated byte sum over the twelve header bytes.
    function automatic logic [31:0] header_sum(
        input logic [31:0] seq,
        input logic [31:0] mark,
        input logic [15:0] size,
        input logic [15:0] ver
    );
        logic [11:0] s;
        s = 12'(seq[7:0]) + 12'(seq[15:8]) + 12'(seq[23:16]) + 12'(seq[31:24])
          + 12'(mark[7:0]) + 12'(mark[15:8]) + 12'(mark[23:16]) + 12'(mark[31:24])
          + 12'(size[7:0]) + 12'(size[15:8]) + 12'(ver[7:0]) + 12'(ver[15:8]);
        return 32'(~{20'd0, s} + 32'd1);
    endfunction

    // Following slot in the rotation, kept in two bits.
    function automatic logic [1:0] next_slot_of(input logic [1:0] s);
        logic [8:0] t;
        t = {7'd0, s} + 9'd1;
        if (t >= SLOT_WRAP)
        begin
            t = t - SLOT_WRAP;
        end
        if (t >= SLOT_WRAP)
        begin
            t = t - SLOT_WRAP;
        end
        return t[1:0];
    endfunction

endpackage

// ----- sv/fsw_stream_if.sv -----
// Valid/ready channel carrying one item of a given payload type.
// Used for both the request and the result channel of the wear leveller.
interface fsw_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- sv/fsw_cfg_regs.sv -----
// Configuration registers of the wear leveller: marker, version, size limit.
// Depends on fsw_pkg for the register indexes and reset values.
module fsw_cfg_regs
    import fsw_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    logic [31:0] marker_reg;
    logic [15:0] version_reg;
    logic [15:0] max_pay_reg;

    // Register writes; an index beyond the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marker_reg  <= MARKER_RESET;
            version_reg <= VERSION_RESET;
            max_pay_reg <= MAX_PAY_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_MARKER:  marker_reg  <= cfg_data;
                CFG_VERSION: version_reg <= cfg_data[15:0];
                CFG_MAX_PAY: max_pay_reg <= cfg_data[15:0];
                default:     ;
            endcase
        end
    end

    assign cfg.marker      = marker_reg;
    assign cfg.version     = version_reg;
    assign cfg.max_payload = max_pay_reg;

endmodule

// ----- sv/fsw_hdr_check.sv -----
// Header checker: validates a scanned header and builds the checksum of a
// prepared one through one shared byte-sum tree. Depends on fsw_pkg.
module fsw_hdr_check
    import fsw_pkg::*;
(
    input  cfg_t        cfg,
    input  in_item_t    item,
    input  logic [31:0] newest_seq,
    output chk_t        chk
);

    logic        is_prepare;
    logic [31:0] prep_seq;
    logic [31:0] sum_seq;
    logic [31:0] sum_mark;
    logic [15:0] sum_ver;
    logic [31:0] checksum;

    // A prepare sums the header it is about to write; a scan sums the stored one.
    assign is_prepare = (item.operation == OP_PREPARE);
    assign prep_seq   = newest_seq + 32'd1;
    assign sum_seq    = is_prepare ? prep_seq : item.stored_sequence;
    assign sum_mark   = is_prepare ? cfg.marker : item.stored_marker;
    assign sum_ver    = is_prepare ? cfg.version : item.stored_version;
    assign checksum   = header_sum(sum_seq, sum_mark, item.payload_size, sum_ver);

    // All header checks of a scanned slot.
    assign chk.hdr_ok = (item.stored_marker == cfg.marker)
                     && (item.stored_version == cfg.version)
                     && (item.payload_size != 16'd0)
                     && (item.payload_size <= cfg.max_payload)
                     && (checksum == item.stored_checksum);
    assign chk.checksum = checksum;
    assign chk.prep_seq = prep_seq;

endmodule

// ----- sv/flash_slot_wear_leveler.sv -----
// Top level of the flash slot wear leveller: input register, record state,
// result register. Depends on fsw_pkg, fsw_stream_if, fsw_cfg_regs, fsw_hdr_check.
//
//  Channel  Dir  Payload     Handshake
//  req      in   in_item_t   valid/ready
//  rsp      out  out_item_t  valid/ready
//  cfg      in   index/data  cfg_wr_en, no wait
//
// Each item is accepted into the input register, then passes through the header
// checker into the result register.
// One item is accepted every cycle unless rsp stalls; the record state is updated
// in the same cycle as the result register, so the next item sees it at once.
// Reset clears the record state and both valid flags; no clearing pass.
// A stall on rsp holds the result and backs up into req only when both stages are full.
module flash_slot_wear_leveler
    import fsw_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    fsw_stream_if.sink            req,
    fsw_stream_if.source          rsp,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t      cfg;
    chk_t      chk;

    logic      s1_valid_reg;
    logic      s1_valid_next;
    in_item_t  s1_item_reg;
    logic      res_valid_reg;
    logic      res_valid_next;
    out_item_t res_item_reg;
    out_item_t res_item_next;

    logic [1:0]  newest_slot_reg;
    logic [1:0]  newest_slot_next;
    logic [31:0] newest_seq_reg;
    logic [31:0] newest_seq_next;
    logic [1:0]  write_slot_reg;
    logic [1:0]  write_slot_next;
    logic        found_reg;
    logic        found_next;
    logic        ready_flag_reg;
    logic        ready_flag_next;

    logic        req_accept;
    logic        res_load;
    logic        s1_advance;

    // Scan working values.
    logic        in_range;
    logic        scan_start;
    logic [1:0]  base_slot;
    logic [31:0] base_seq;
    logic        base_found;
    logic        base_ready;
    logic        slot_ok;
    logic        wins;
    logic [31:0] seq_diff;

    fsw_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    fsw_hdr_check u_chk (
        .cfg        (cfg),
        .item       (s1_item_reg),
        .newest_seq (newest_seq_reg),
        .chk        (chk)
    );

    // Handshake between the two stages.
    assign res_load   = !res_valid_reg || rsp.ready;
    assign s1_advance = s1_valid_reg && res_load;
    assign req.ready  = !s1_valid_reg || res_load;
    assign req_accept = req.valid && req.ready;

    assign s1_valid_next  = req_accept ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_reg);
    assign res_valid_next = s1_advance ? 1'b1 : (rsp.ready ? 1'b0 : res_valid_reg);

    // Scan bookkeeping: a scan of slot zero starts from a cleared record.
    assign in_range   = ({6'd0, s1_item_reg.slot_index} < SLOT_LIMIT);
    assign scan_start = (s1_item_reg.slot_index == 2'd0);
    assign base_slot  = scan_start ? 2'd0 : newest_slot_reg;
    assign base_seq   = scan_start ? 32'd0 : newest_seq_reg;
    assign base_found = scan_start ? 1'b0 : found_reg;
    assign base_ready = scan_start ? 1'b0 : ready_flag_reg;
    assign seq_diff   = s1_item_reg.stored_sequence - base_seq;
    assign wins       = !base_found || (seq_diff < SERIAL_HALF);
    assign slot_ok    = (s1_item_reg.operation == OP_SCAN) && in_range && chk.hdr_ok;

    // Next record state and result for the item in the input register.
    always_comb
    begin
        newest_slot_next = newest_slot_reg;
        newest_seq_next  = newest_seq_reg;
        write_slot_next  = write_slot_reg;
        found_next       = found_reg;
        ready_flag_next  = ready_flag_reg;
        case (s1_item_reg.operation)
            OP_SCAN:
            begin
                if (in_range)
                begin
                    newest_slot_next = base_slot;
                    newest_seq_next  = base_seq;
                    if (slot_ok && wins)
                    begin
                        newest_slot_next = s1_item_reg.slot_index;
                        newest_seq_next  = s1_item_reg.stored_sequence;
                    end
                    found_next      = base_found || slot_ok;
                    write_slot_next = found_next ? next_slot_of(newest_slot_next) : 2'd0;
                    ready_flag_next = base_ready
                                   || ({6'd0, s1_item_reg.slot_index} == LAST_SLOT);
                end
            end
            OP_PREPARE: ;
            OP_COMMIT:
            begin
                newest_slot_next = write_slot_reg;
                newest_seq_next  = newest_seq_reg + 32'd1;
                write_slot_next  = next_slot_of(write_slot_reg);
                found_next       = 1'b1;
            end
            OP_ERASE:
            begin
                newest_slot_next = 2'd0;
                newest_seq_next  = 32'd0;
                write_slot_next  = 2'd0;
                found_next       = 1'b0;
                ready_flag_next  = 1'b1;
            end
            default: ;
        endcase

        res_item_next.slot_valid      = slot_ok;
        res_item_next.record_slot     = newest_slot_next;
        res_item_next.newest_sequence = newest_seq_next;
        res_item_next.next_slot       = write_slot_next;
        res_item_next.config_found    = found_next;
        res_item_next.scan_done       = ready_flag_next;
        res_item_next.new_sequence    = 32'd0;
        res_item_next.new_checksum    = 32'd0;
        if (s1_item_reg.operation == OP_PREPARE)
        begin
            res_item_next.new_sequence = chk.prep_seq;
            res_item_next.new_checksum = chk.checksum;
        end
    end

    // Control state: valid flags and the record.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            res_valid_reg   <= 1'b0;
            newest_slot_reg <= 2'd0;
            newest_seq_reg  <= 32'd0;
            write_slot_reg  <= 2'd0;
            found_reg       <= 1'b0;
            ready_flag_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
            if (s1_advance)
            begin
                newest_slot_reg <= newest_slot_next;
                newest_seq_reg  <= newest_seq_next;
                write_slot_reg  <= write_slot_next;
                found_reg       <= found_next;
                ready_flag_reg  <= ready_flag_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            s1_item_reg <= req.data;
        end
        if (s1_advance)
        begin
            res_item_reg <= res_item_next;
        end
    end

    assign rsp.valid = res_valid_reg;
    assign rsp.data  = res_item_reg;

    // A commit always leaves a known record.
    a_commit_found: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && s1_item_reg.operation == OP_COMMIT) |=> found_reg)
        else $error("commit did not set the found flag");

    // An erase clears the record and marks the state as built.
    a_erase_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && s1_item_reg.operation == OP_ERASE)
        |=> (ready_flag_reg && !found_reg && newest_seq_reg == 32'd0))
        else $error("erase left a stale record");

    // Only a scan can report a valid slot.
    a_valid_scan_only: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && s1_item_reg.operation != OP_SCAN) |=> !res_item_reg.slot_valid)
        else $error("slot_valid raised outside a scan");

    // Prepared header words are zero unless the item was a prepare.
    a_prepare_only: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && s1_item_reg.operation != OP_PREPARE)
        |=> (res_item_reg.new_sequence == 32'd0 && res_item_reg.new_checksum == 32'd0))
        else $error("prepare outputs set by another operation");

    // An empty input register always takes an item.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> req.ready)
        else $error("input stalled while the input register was empty");

endmodule
